### design/kvlp_pkg.sv
// ----------------------------------------------------------------------------
// kvlp_pkg
// Shared constants, widths and character classes for the properties line
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package kvlp_pkg;

   localparam int NAME_CAPACITY  = 32;
   localparam int VALUE_CAPACITY = 32;

   localparam int NAME_AW  = $clog2(NAME_CAPACITY);
   localparam int VALUE_AW = $clog2(VALUE_CAPACITY);
   localparam int FILL_W   = (NAME_AW > VALUE_AW) ? NAME_AW : VALUE_AW;
   localparam int TOTAL_W  = $clog2(NAME_CAPACITY + VALUE_CAPACITY);

   localparam int BYTE_W = 8;
   localparam int CHAR_W = 7;
   localparam int KIND_W = 2;
   localparam int LINE_W = 16;

   localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPT = 2'd0,
      KIND_ERROR  = 2'd1,
      KIND_NAME   = 2'd2,
      KIND_VALUE  = 2'd3
   } kind_type;

   localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_USCORE = 8'h5F;
   localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

   function automatic logic is_name_char(input logic [BYTE_W-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CH_USCORE || c == CH_DASH ||
             c == CH_DOT;
   endfunction

   function automatic logic is_blank(input logic [BYTE_W-1:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

endpackage

`default_nettype wire

### design/kvlp_ifs.sv
// ----------------------------------------------------------------------------
// kvlp channel interfaces
// Valid/ready channels for raw text bytes and for parser results.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvlp_req_if;
   logic                        valid;
   logic                        ready;
   logic [kvlp_pkg::BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface kvlp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [kvlp_pkg::KIND_W-1:0] kind;
   logic [kvlp_pkg::CHAR_W-1:0] out_char;
   logic                        last;
   logic [kvlp_pkg::LINE_W-1:0] line_number;

   modport source (output valid, output kind, output out_char, output last,
                   output line_number, input ready);
   modport sink (input valid, input kind, input out_char, input last,
                 input line_number, output ready);
endinterface

`default_nettype wire

### design/key_value_line_parser.sv
// ----------------------------------------------------------------------------
// key_value_line_parser
// Byte-serial properties text parser with name/value buffers and a
// character-by-character property emitter.
// ----------------------------------------------------------------------------
// Each accepted byte normally yields one accepted/error transfer. A line feed
// that completes a property instead yields the stored name characters and then
// the value characters (trailing blanks dropped), the final one flagged last;
// each character is read from its store into a read register and then loaded
// into the output register, and no byte is taken until the last one is loaded
// into the output register. Errors carry the line number the byte sits on.
`default_nettype none

module key_value_line_parser (
   input  wire           clock,
   input  wire           reset,
   kvlp_req_if.sink      req_chan,
   kvlp_rsp_if.source    rsp_chan
);

   typedef enum logic [4:0] {
      PH_WAIT_NAME  = 5'b00001,
      PH_COPY_NAME  = 5'b00010,
      PH_WAIT_VALUE = 5'b00100,
      PH_COPY_VALUE = 5'b01000,
      PH_COMMENT    = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      SQ_IDLE = 3'b001,
      SQ_READ = 3'b010,
      SQ_SEND = 3'b100
   } seq_type;

   phase_type                       phase_ff, phase_in;
   seq_type                         seq_ff, seq_in;
   logic [kvlp_pkg::FILL_W-1:0]     fill_ff, fill_in;
   logic [kvlp_pkg::NAME_AW-1:0]    name_len_ff, name_len_in;
   logic [kvlp_pkg::VALUE_AW-1:0]   trim_len_ff, trim_len_in;
   logic [kvlp_pkg::LINE_W-1:0]     line_ff, line_in;
   logic [kvlp_pkg::TOTAL_W-1:0]    idx_ff, idx_in;
   logic [kvlp_pkg::TOTAL_W-1:0]    total_ff, total_in;
   logic [kvlp_pkg::LINE_W-1:0]     emit_line_ff, emit_line_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [kvlp_pkg::KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [kvlp_pkg::CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [kvlp_pkg::LINE_W-1:0]     rsp_line_ff, rsp_line_in;

   logic [kvlp_pkg::CHAR_W-1:0]     name_mem [kvlp_pkg::NAME_CAPACITY];
   logic [kvlp_pkg::CHAR_W-1:0]     value_mem [kvlp_pkg::VALUE_CAPACITY];
   logic [kvlp_pkg::CHAR_W-1:0]     name_rd_ff;
   logic [kvlp_pkg::CHAR_W-1:0]     value_rd_ff;
   logic [kvlp_pkg::NAME_AW-1:0]    name_rd_addr;
   logic [kvlp_pkg::VALUE_AW-1:0]   value_rd_addr;
   logic [kvlp_pkg::TOTAL_W-1:0]    value_offset;

   logic                            name_we, value_we;
   logic [kvlp_pkg::CHAR_W-1:0]     wr_char;

   logic [kvlp_pkg::BYTE_W-1:0]     c;
   logic                            accept, slot_free;
   logic                            ok, emit;
   logic [kvlp_pkg::VALUE_AW-1:0]   emit_vlen;
   logic [kvlp_pkg::LINE_W-1:0]     line_next;
   logic [kvlp_pkg::FILL_W:0]       fill_inc;
   logic                            idx_is_name, idx_is_last;

   assign c         = req_chan.in_byte;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (seq_ff == SQ_IDLE) && slot_free;
   assign accept    = req_chan.valid && req_chan.ready;

   assign line_next = (line_ff != kvlp_pkg::LINE_MAX) ? line_ff + 1'b1 : line_ff;
   assign fill_inc  = {1'b0, fill_ff} + 1'b1;
   assign wr_char   = c[kvlp_pkg::CHAR_W-1:0];

   // byte decode and parse state update
   always_comb begin
      phase_in    = phase_ff;
      fill_in     = fill_ff;
      name_len_in = name_len_ff;
      trim_len_in = trim_len_ff;
      line_in     = line_ff;
      ok          = 1'b1;
      emit        = 1'b0;
      emit_vlen   = '0;
      name_we     = 1'b0;
      value_we    = 1'b0;
      if (c != kvlp_pkg::CH_CR) begin
         case (phase_ff)
            PH_COPY_NAME: begin
               if (kvlp_pkg::is_name_char(c)) begin
                  if (fill_ff >= kvlp_pkg::FILL_W'(kvlp_pkg::NAME_CAPACITY - 2)) begin
                     ok = 1'b0;
                  end else begin
                     name_we     = 1'b1;
                     fill_in     = fill_inc[kvlp_pkg::FILL_W-1:0];
                     name_len_in = fill_inc[kvlp_pkg::NAME_AW-1:0];
                  end
               end else if (c == kvlp_pkg::CH_EQ || kvlp_pkg::is_blank(c)) begin
                  phase_in = PH_WAIT_VALUE;
                  fill_in  = '0;
               end else if (c == kvlp_pkg::CH_LF) begin
                  emit     = 1'b1;
                  phase_in = PH_WAIT_NAME;
                  fill_in  = '0;
                  line_in  = line_next;
               end else begin
                  ok = 1'b0;
               end
            end
            PH_WAIT_VALUE: begin
               if (c == kvlp_pkg::CH_EQ || kvlp_pkg::is_blank(c)) begin
                  ok = 1'b1;
               end else if (c == kvlp_pkg::CH_LF) begin
                  emit     = 1'b1;
                  phase_in = PH_WAIT_NAME;
                  fill_in  = '0;
                  line_in  = line_next;
               end else if (c > kvlp_pkg::CH_SPACE && c <= kvlp_pkg::CH_TILDE) begin
                  value_we    = 1'b1;
                  fill_in     = kvlp_pkg::FILL_W'(1);
                  trim_len_in = kvlp_pkg::VALUE_AW'(1);
                  phase_in    = PH_COPY_VALUE;
               end else begin
                  ok = 1'b0;
               end
            end
            PH_COPY_VALUE: begin
               if (c == kvlp_pkg::CH_LF) begin
                  emit      = 1'b1;
                  emit_vlen = trim_len_ff;
                  phase_in  = PH_WAIT_NAME;
                  fill_in   = '0;
                  line_in   = line_next;
               end else if (c < kvlp_pkg::CH_SPACE || c > kvlp_pkg::CH_TILDE) begin
                  ok = 1'b0;
               end else if (fill_ff >= kvlp_pkg::FILL_W'(kvlp_pkg::VALUE_CAPACITY - 2)) begin
                  ok = 1'b0;
               end else begin
                  value_we = 1'b1;
                  fill_in  = fill_inc[kvlp_pkg::FILL_W-1:0];
                  // trimmed length tracks the last non-blank character
                  if (!kvlp_pkg::is_blank(c)) begin
                     trim_len_in = fill_inc[kvlp_pkg::VALUE_AW-1:0];
                  end
               end
            end
            PH_COMMENT: begin
               if (c == kvlp_pkg::CH_LF) begin
                  phase_in = PH_WAIT_NAME;
                  fill_in  = '0;
                  line_in  = line_next;
               end
            end
            default: begin
               if (kvlp_pkg::is_blank(c)) begin
                  ok = 1'b1;
               end else if (c == kvlp_pkg::CH_LF) begin
                  line_in = line_next;
               end else if (c == kvlp_pkg::CH_HASH) begin
                  phase_in = PH_COMMENT;
               end else if (kvlp_pkg::is_name_char(c)) begin
                  if (fill_ff >= kvlp_pkg::FILL_W'(kvlp_pkg::NAME_CAPACITY - 2)) begin
                     ok = 1'b0;
                  end else begin
                     name_we     = 1'b1;
                     fill_in     = fill_inc[kvlp_pkg::FILL_W-1:0];
                     name_len_in = fill_inc[kvlp_pkg::NAME_AW-1:0];
                     phase_in    = PH_COPY_NAME;
                  end
               end else begin
                  ok = 1'b0;
               end
            end
         endcase
      end
   end

   // emit sequencer: one store read, then one output load, per character
   assign value_offset  = idx_ff - {{(kvlp_pkg::TOTAL_W-kvlp_pkg::NAME_AW){1'b0}}, name_len_ff};
   assign name_rd_addr  = idx_ff[kvlp_pkg::NAME_AW-1:0];
   assign value_rd_addr = value_offset[kvlp_pkg::VALUE_AW-1:0];
   assign idx_is_name   = idx_ff < {{(kvlp_pkg::TOTAL_W-kvlp_pkg::NAME_AW){1'b0}}, name_len_ff};
   assign idx_is_last   = (idx_ff + 1'b1) == total_ff;

   always_comb begin
      seq_in       = seq_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      emit_line_in = emit_line_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_line_in  = rsp_line_ff;
      case (seq_ff)
         SQ_IDLE: begin
            if (accept) begin
               if (emit) begin
                  seq_in       = SQ_READ;
                  idx_in       = '0;
                  total_in     = kvlp_pkg::TOTAL_W'(name_len_ff) +
                                 kvlp_pkg::TOTAL_W'(emit_vlen);
                  emit_line_in = line_ff;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = ok ? kvlp_pkg::KIND_ACCEPT : kvlp_pkg::KIND_ERROR;
                  rsp_char_in  = '0;
                  rsp_last_in  = 1'b1;
                  rsp_line_in  = line_ff;
               end
            end
         end
         SQ_READ: begin
            seq_in = SQ_SEND;
         end
         SQ_SEND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = idx_is_name ? kvlp_pkg::KIND_NAME : kvlp_pkg::KIND_VALUE;
               rsp_char_in  = idx_is_name ? name_rd_ff : value_rd_ff;
               rsp_last_in  = idx_is_last;
               rsp_line_in  = emit_line_ff;
               if (idx_is_last) begin
                  seq_in = SQ_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  seq_in = SQ_READ;
               end
            end
         end
         default: begin
            seq_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (name_we && accept) begin
         name_mem[fill_ff[kvlp_pkg::NAME_AW-1:0]] <= wr_char;
      end
      if (value_we && accept) begin
         value_mem[fill_ff[kvlp_pkg::VALUE_AW-1:0]] <= wr_char;
      end
      name_rd_ff  <= name_mem[name_rd_addr];
      value_rd_ff <= value_mem[value_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT_NAME;
         seq_ff       <= SQ_IDLE;
         fill_ff      <= '0;
         name_len_ff  <= '0;
         trim_len_ff  <= '0;
         line_ff      <= kvlp_pkg::LINE_W'(1);
         idx_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            fill_ff     <= fill_in;
            name_len_ff <= name_len_in;
            trim_len_ff <= trim_len_in;
            line_ff     <= line_in;
         end
         seq_ff       <= seq_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_line_ff <= emit_line_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_line_ff  <= rsp_line_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = rsp_kind_ff;
   assign rsp_chan.out_char    = rsp_char_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.line_number = rsp_line_ff;

`ifndef NO_ASSERTIONS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      seq_ff != SQ_IDLE |-> idx_ff < total_ff)
      else $error("emit index past property length");

   a_name_fill: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COPY_NAME |->
         (kvlp_pkg::FILL_W'(name_len_ff) == fill_ff) && name_len_ff != '0)
      else $error("name length out of step with fill index");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter wrapped");

   a_emit_holds_input: assert property (@(posedge clock) disable iff (reset)
      seq_ff == SQ_READ |=> $stable(line_ff) && $stable(phase_ff))
      else $error("parse state moved during property emit");
`endif

endmodule

`default_nettype wire

### sim/kvlp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kvlp_result_checker
// Watches both parser channels, predicts the result transfers of every text
// byte taken and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module kvlp_result_checker (
   input  wire  clock,
   input  wire  reset,
   kvlp_req_if  req_mon,
   kvlp_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   pending_count,
   output int   checked_count
);
   import kvlp_pkg::*;

   typedef enum logic [2:0] {
      PH_WAIT_NAME  = 3'd0,
      PH_COPY_NAME  = 3'd1,
      PH_WAIT_VALUE = 3'd2,
      PH_COPY_VALUE = 3'd3,
      PH_COMMENT    = 3'd4
   } phase_type;

   typedef struct packed {
      kind_type          kind;
      logic [CHAR_W-1:0] out_char;
      logic              last;
      logic [LINE_W-1:0] line_number;
   } result_type;

   phase_type         phase;
   logic [FILL_W-1:0] fill_idx;
   logic [FILL_W-1:0] name_len;
   logic [CHAR_W-1:0] name_buf [NAME_CAPACITY];
   logic [CHAR_W-1:0] value_buf [VALUE_CAPACITY];
   logic [LINE_W-1:0] line_cnt;
   result_type        expected_q[$];

   function automatic logic blank_char(input logic [BYTE_W-1:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   // bit 5 folds lower case onto upper case; bit 7 keeps high bytes out
   function automatic logic name_char_ok(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] folded;
      folded = c & 8'hDF;
      return (folded >= "A" && folded <= "Z") || (c >= "0" && c <= "9") ||
             c == CH_USCORE || c == CH_DASH || c == CH_DOT;
   endfunction

   function automatic string result_text(input result_type r);
      return $sformatf("kind=%0d char=%02h last=%0d line=%0d",
                       r.kind, r.out_char, r.last, r.line_number);
   endfunction

   task automatic push_result(input kind_type kind, input logic [CHAR_W-1:0] ch,
                              input logic last, input logic [LINE_W-1:0] line);
      result_type r;
      r.kind        = kind;
      r.out_char    = ch;
      r.last        = last;
      r.line_number = line;
      expected_q.push_back(r);
   endtask

   task automatic next_line();
      phase    = PH_WAIT_NAME;
      fill_idx = '0;
      if (line_cnt != LINE_MAX) line_cnt = line_cnt + 1'b1;
   endtask

   task automatic store_name_char(input logic [BYTE_W-1:0] c);
      name_buf[fill_idx] = c[CHAR_W-1:0];
      fill_idx           = fill_idx + 1'b1;
      name_len           = fill_idx;
   endtask

   task automatic emit_property(input int value_len, input logic [LINE_W-1:0] line);
      int total;
      int k;
      total = name_len + value_len;
      k     = 0;
      for (int i = 0; i < name_len; i++) begin
         k++;
         push_result(KIND_NAME, name_buf[i], k == total, line);
      end
      for (int i = 0; i < value_len; i++) begin
         k++;
         push_result(KIND_VALUE, value_buf[i], k == total, line);
      end
      next_line();
   endtask

   task automatic parse_byte(input logic [BYTE_W-1:0] c);
      logic [LINE_W-1:0] line;
      logic              ok;
      logic              emitted;
      int                len;
      line    = line_cnt;
      ok      = 1'b1;
      emitted = 1'b0;
      if (c != CH_CR) begin
         case (phase)
            PH_COPY_NAME: begin
               if (name_char_ok(c)) begin
                  if (fill_idx >= NAME_CAPACITY - 2) ok = 1'b0;
                  else store_name_char(c);
               end else if (c == CH_EQ || blank_char(c)) begin
                  phase    = PH_WAIT_VALUE;
                  fill_idx = '0;
               end else if (c == CH_LF) begin
                  emit_property(0, line);
                  emitted = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            PH_WAIT_VALUE: begin
               if (c == CH_EQ || blank_char(c)) begin
               end else if (c == CH_LF) begin
                  emit_property(0, line);
                  emitted = 1'b1;
               end else if (c > CH_SPACE && c <= CH_TILDE) begin
                  value_buf[0] = c[CHAR_W-1:0];
                  fill_idx     = FILL_W'(1);
                  phase        = PH_COPY_VALUE;
               end else begin
                  ok = 1'b0;
               end
            end
            PH_COPY_VALUE: begin
               if (c == CH_LF) begin
                  len = fill_idx;
                  while (len > 1 && (value_buf[len-1] == CH_SPACE[CHAR_W-1:0] ||
                                     value_buf[len-1] == CH_TAB[CHAR_W-1:0]))
                     len--;
                  emit_property(len, line);
                  emitted = 1'b1;
               end else if (c < CH_SPACE || c > CH_TILDE) begin
                  ok = 1'b0;
               end else if (fill_idx >= VALUE_CAPACITY - 2) begin
                  ok = 1'b0;
               end else begin
                  value_buf[fill_idx] = c[CHAR_W-1:0];
                  fill_idx            = fill_idx + 1'b1;
               end
            end
            PH_COMMENT: begin
               if (c == CH_LF) next_line();
            end
            default: begin
               if (blank_char(c)) begin
               end else if (c == CH_LF) begin
                  if (line_cnt != LINE_MAX) line_cnt = line_cnt + 1'b1;
               end else if (c == CH_HASH) begin
                  phase = PH_COMMENT;
               end else if (name_char_ok(c)) begin
                  if (fill_idx >= NAME_CAPACITY - 2) begin
                     ok = 1'b0;
                  end else begin
                     store_name_char(c);
                     phase = PH_COPY_NAME;
                  end
               end else begin
                  ok = 1'b0;
               end
            end
         endcase
      end
      if (!emitted) push_result(ok ? KIND_ACCEPT : KIND_ERROR, '0, 1'b1, line);
   endtask

   task automatic report_failure(input string msg);
      mismatch_count++;
      $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_result();
      result_type want;
      result_type got;
      got.kind        = kind_type'(rsp_mon.kind);
      got.out_char    = rsp_mon.out_char;
      got.last        = rsp_mon.last;
      got.line_number = rsp_mon.line_number;
      checked_count++;
      if (expected_q.size() == 0) begin
         report_failure({"unexpected result, expected none, actual ", result_text(got)});
      end else begin
         want = expected_q.pop_front();
         if (want.kind !== got.kind || want.out_char !== got.out_char ||
             want.last !== got.last || want.line_number !== got.line_number)
            report_failure({"result mismatch, expected ", result_text(want),
                            ", actual ", result_text(got)});
      end
   endtask

   // predictions are queued before the compare so a same-edge result still finds its entry
   always @(posedge clock) begin
      if (reset) begin
         phase          = PH_WAIT_NAME;
         fill_idx       = '0;
         name_len       = '0;
         line_cnt       = LINE_W'(1);
         mismatch_count = 0;
         checked_count  = 0;
         expected_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) parse_byte(req_mon.in_byte);
         if (rsp_mon.valid && rsp_mon.ready) check_result();
      end
      pending_count = expected_q.size();
   end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives properties text into the line parser under shifting idle mixes,
// including malformed lines, comments and overlong names and values.
// ----------------------------------------------------------------------------

module tb;
   import kvlp_pkg::*;

   logic clock;
   logic reset;

   kvlp_req_if req_bus ();
   kvlp_rsp_if rsp_bus ();

   int                send_idle_pct;
   int                recv_idle_pct;
   int                mismatch_count;
   int                pending_count;
   int                checked_count;
   int                bytes_sent;
   int                lines_sent;
   int                drain_cycles;
   logic [BYTE_W-1:0] line_q[$];

   key_value_line_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   kvlp_result_checker result_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [BYTE_W-1:0] name_char();
      int r;
      r = $urandom_range(64);
      if (r < 26) return BYTE_W'("A" + r);
      else if (r < 52) return BYTE_W'("a" + r - 26);
      else if (r < 62) return BYTE_W'("0" + r - 52);
      else if (r == 62) return CH_USCORE;
      else if (r == 63) return CH_DASH;
      else return CH_DOT;
   endfunction

   function automatic logic [BYTE_W-1:0] blank_char();
      return $urandom_range(1) ? CH_SPACE : CH_TAB;
   endfunction

   function automatic logic [BYTE_W-1:0] sep_char();
      return ($urandom_range(2) == 0) ? CH_EQ : blank_char();
   endfunction

   function automatic logic [BYTE_W-1:0] value_char();
      logic [BYTE_W-1:0] c;
      c = BYTE_W'($urandom_range(126, 32));
      if ($urandom_range(19) == 0) c = CH_TAB;
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] noise_byte();
      logic [BYTE_W-1:0] c;
      c = BYTE_W'($urandom_range(255));
      if (c == CH_LF) c = 8'h00;
      return c;
   endfunction

   // called on a falling edge, returns on the falling edge after the transfer
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_directed();
      send_byte(CH_CR);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_HASH);
      send_byte(8'h80);
      send_byte(CH_TILDE);
      send_byte(CH_LF);
      send_text("k=~ \t\n");
      send_text("n\n");
      send_text("\n");
      send_text("q=r");
      send_byte(8'h01);
      send_byte(CH_LF);
      send_text("z.");
      send_byte(8'h7F);
      send_text("=\n");
   endtask

   task automatic send_random_line();
      int pick;
      int count;
      line_q.delete();
      pick = $urandom_range(99);
      if (pick < 65) begin
         if ($urandom_range(9) == 0) line_q.push_back(blank_char());
         count = ($urandom_range(9) == 0) ? $urandom_range(32, 28) : $urandom_range(8, 1);
         repeat (count) line_q.push_back(name_char());
         if ($urandom_range(6) != 0) begin
            count = $urandom_range(3, 1);
            repeat (count) line_q.push_back(sep_char());
            count = ($urandom_range(9) == 0) ? $urandom_range(32, 28) : $urandom_range(10, 1);
            line_q.push_back(BYTE_W'($urandom_range(126, 33)));
            repeat (count - 1) line_q.push_back(value_char());
            count = $urandom_range(3);
            repeat (count) line_q.push_back(blank_char());
         end
         if ($urandom_range(9) == 0) line_q[$urandom_range(line_q.size() - 1)] = noise_byte();
      end else if (pick < 77) begin
         if ($urandom_range(3) == 0) line_q.push_back(blank_char());
         line_q.push_back(CH_HASH);
         count = $urandom_range(8);
         repeat (count) line_q.push_back(noise_byte());
      end else if (pick < 85) begin
         count = $urandom_range(2);
         repeat (count) line_q.push_back(blank_char());
      end else begin
         count = $urandom_range(6, 1);
         repeat (count) line_q.push_back(noise_byte());
      end
      if ($urandom_range(4) == 0) line_q.push_back(CH_CR);
      line_q.push_back(CH_LF);
      foreach (line_q[j]) send_byte(line_q[j]);
      lines_sent++;
   endtask

   task automatic send_random_text(input int min_bytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < min_bytes) send_random_line();
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = '0;
      rsp_bus.ready   = 1'b0;
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      bytes_sent      = 0;
      lines_sent      = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 12;
      recv_idle_pct = 52;
      send_directed();
      send_random_text(55);

      send_idle_pct = 52;
      recv_idle_pct = 12;
      send_random_text(55);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_text(45);
      req_bus.valid <= 1'b0;

      drain_cycles = 0;
      while (pending_count != 0 && drain_cycles < 200000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (200) @(negedge clock);
      if (pending_count != 0)
         $display("%0t ns: %0d expected results never arrived", $time, pending_count);

      $display("Sent %0d text bytes (%0d random lines), checked %0d result transfers",
               bytes_sent, lines_sent, checked_count);
      $display("Idle mixes 12/52, 52/12 and none; comments, bad bytes and full buffers");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
